// ===== sv/fbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fbr_pkg;

    localparam int FRAME_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;
    localparam int CMD_COUNT  = 3;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;

    localparam logic [FRAME_W-1:0] BLINK_ON_RESET   = 4'd4;
    localparam logic [FRAME_W-1:0] BLINK_LAST_RESET = 4'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_LAST = 4'd1;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_FLASH = 2'd1,
        OP_CLEAR = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

// ===== sv/fbr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fbr_in_if;
    logic             valid;
    logic             ready;
    fbr_pkg::op_t     operation;
    logic [7:0]       pixel_row;
    logic [7:0]       pixel_col;
    logic             pixel_on;

    modport source (output valid, operation, pixel_row, pixel_col, pixel_on, input ready);
    modport sink   (input valid, operation, pixel_row, pixel_col, pixel_on, output ready);
endinterface

`default_nettype wire

// ===== sv/fbr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fbr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       frame_last;

    modport source (output valid, lcd_byte, is_data, frame_last, input ready);
    modport sink   (input valid, lcd_byte, is_data, frame_last, output ready);
endinterface

`default_nettype wire

// ===== sv/fbr_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fbr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fbr_pkg::CFG_IDX_W-1:0]    index;
    logic [fbr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/fbr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/framebuffer_blink_refresh_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pixel write: accepted in idle, read-modify-write of one store byte.
// Refresh tick: one memory read, then the result is registered into the output once out is free.
// A new item is taken only in idle, so one item must finish before the next is accepted.
// Clear: sweeps both stores one byte a cycle, then returns to idle.
// Reset runs the same clearing pass before the first item is taken;
// configuration writes are taken throughout.
module framebuffer_blink_refresh_unit #(
    parameter int PANEL_COLUMNS = 128,
    parameter int PANEL_ROWS    = 64,
    parameter int STORE_BYTES   = 1024
) (
    input wire logic  clk,
    input wire logic  rst_n,
    fbr_in_if.sink    in_ch,
    fbr_out_if.source out_ch,
    fbr_cfg_if.sink   cfg_ch
);

    localparam int PAGES    = PANEL_ROWS / 8;
    localparam int PAGE_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int POS_MAX  = fbr_pkg::CMD_COUNT + PANEL_COLUMNS - 1;
    localparam int POS_W    = $clog2(POS_MAX + 1);
    localparam int ROW_W    = $clog2(PANEL_ROWS);
    localparam int LIN_W    = $clog2(PAGES * PANEL_COLUMNS + 1);
    localparam int ADDR_W   = $clog2(STORE_BYTES);

    fbr_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [PAGE_W-1:0]           page_reg, page_next;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [fbr_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic [fbr_pkg::FRAME_W-1:0] blink_on_reg, blink_last_reg;

    logic [ADDR_W-1:0] wr_addr_reg;
    logic [2:0]        wr_bit_reg;
    logic              wr_on_reg;
    logic              wr_mask_reg;
    logic              wr_ok_reg;

    logic              sc_data_reg;
    logic [7:0]        sc_cmd_reg;
    logic              sc_last_reg;
    logic              sc_blank_reg;
    logic              sc_ok_reg;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_data_reg;
    logic              out_last_reg;

    logic              accept;
    logic              out_free;
    logic              out_load;

    logic [ROW_W-1:0]  flip;
    logic [LIN_W-1:0]  pix_lin;
    logic              pix_ok;
    logic [LIN_W-1:0]  scan_lin;
    logic              pos_is_data;
    logic              pos_end;
    logic              page_end;
    logic [7:0]        cmd_byte;

    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ADDR_W-1:0] ram_waddr;
    logic              pix_we, msk_we;
    logic [7:0]        pix_rdata, msk_rdata;
    logic [7:0]        pix_wdata, msk_wdata;
    logic [7:0]        mod_byte;
    logic [7:0]        scan_byte;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign cfg_ch.ready = 1'b1;

    // Rotated pixel addressing
    assign flip    = ROW_W'(PANEL_ROWS - 1) - in_ch.pixel_col[ROW_W-1:0];
    assign pix_lin = LIN_W'(flip >> 3) * LIN_W'(PANEL_COLUMNS) + LIN_W'(in_ch.pixel_row);
    assign pix_ok  = (9'(in_ch.pixel_row) < 9'(PANEL_COLUMNS))
                  && (in_ch.pixel_col < 8'(PANEL_ROWS))
                  && (32'(pix_lin) < 32'(STORE_BYTES));

    // Scan position decode
    assign pos_is_data = pos_reg >= POS_W'(fbr_pkg::CMD_COUNT);
    assign pos_end     = pos_reg >= POS_W'(POS_MAX);
    assign page_end    = 32'(page_reg) + 32'd1 >= 32'(PAGES);
    assign scan_lin    = LIN_W'(page_reg) * LIN_W'(PANEL_COLUMNS)
                       + LIN_W'(pos_reg - POS_W'(fbr_pkg::CMD_COUNT));

    always_comb
    begin
        unique case (pos_reg)
            POS_W'(0): cmd_byte = fbr_pkg::CMD_PAGE_BASE + 8'(page_reg);
            POS_W'(1): cmd_byte = fbr_pkg::CMD_COL_HIGH;
            default:   cmd_byte = fbr_pkg::CMD_COL_LOW;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            fbr_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (32'(clr_cnt_reg) == STORE_BYTES - 1)
                begin
                    state_next   = fbr_pkg::ST_IDLE;
                    clr_cnt_next = '0;
                end
            end
            fbr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_ch.operation)
                        fbr_pkg::OP_DRAW,
                        fbr_pkg::OP_FLASH: state_next = fbr_pkg::ST_WRITE;
                        fbr_pkg::OP_CLEAR: state_next = fbr_pkg::ST_CLEAR;
                        fbr_pkg::OP_TICK:  state_next = fbr_pkg::ST_SCAN;
                        default:           state_next = fbr_pkg::ST_IDLE;
                    endcase
                end
            end
            fbr_pkg::ST_WRITE:
            begin
                state_next = fbr_pkg::ST_IDLE;
            end
            fbr_pkg::ST_SCAN:
            begin
                if (out_free)
                begin
                    state_next = fbr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fbr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine
    always_comb
    begin
        in_ch.ready = 1'b0;
        pix_we      = 1'b0;
        msk_we      = 1'b0;
        ram_waddr   = wr_addr_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            fbr_pkg::ST_CLEAR:
            begin
                pix_we    = 1'b1;
                msk_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
            end
            fbr_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            fbr_pkg::ST_WRITE:
            begin
                pix_we = wr_ok_reg && !wr_mask_reg;
                msk_we = wr_ok_reg && wr_mask_reg;
            end
            fbr_pkg::ST_SCAN:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    // Store ports
    assign ram_re    = accept;
    assign ram_raddr = (in_ch.operation == fbr_pkg::OP_TICK) ? ADDR_W'(scan_lin)
                                                             : ADDR_W'(pix_lin);

    always_comb
    begin
        if (wr_on_reg)
        begin
            mod_byte = (wr_mask_reg ? msk_rdata : pix_rdata) | (8'd1 << wr_bit_reg);
        end
        else
        begin
            mod_byte = (wr_mask_reg ? msk_rdata : pix_rdata) & ~(8'd1 << wr_bit_reg);
        end
    end

    assign pix_wdata = (state_reg == fbr_pkg::ST_CLEAR) ? 8'd0 : mod_byte;
    assign msk_wdata = (state_reg == fbr_pkg::ST_CLEAR) ? 8'd0 : mod_byte;

    fbr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (ram_waddr),
        .wdata (pix_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (pix_rdata)
    );

    fbr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_mask_ram (
        .clk   (clk),
        .we    (msk_we),
        .waddr (ram_waddr),
        .wdata (msk_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (msk_rdata)
    );

    always_comb
    begin
        priority if (!sc_data_reg)
        begin
            scan_byte = sc_cmd_reg;
        end
        else if (!sc_ok_reg)
        begin
            scan_byte = 8'd0;
        end
        else if (sc_blank_reg)
        begin
            scan_byte = pix_rdata & ~msk_rdata;
        end
        else
        begin
            scan_byte = pix_rdata;
        end
    end

    // Scan and blink counters advance at the tick
    always_comb
    begin
        page_next  = page_reg;
        pos_next   = pos_reg;
        frame_next = frame_reg;
        if (accept && in_ch.operation == fbr_pkg::OP_TICK)
        begin
            if (pos_end)
            begin
                pos_next = '0;
                if (page_end)
                begin
                    page_next  = '0;
                    frame_next = (frame_reg >= blink_last_reg) ? '0
                                                               : frame_reg + 4'd1;
                end
                else
                begin
                    page_next = page_reg + PAGE_W'(1);
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fbr_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            page_reg       <= '0;
            pos_reg        <= '0;
            frame_reg      <= '0;
            blink_on_reg   <= fbr_pkg::BLINK_ON_RESET;
            blink_last_reg <= fbr_pkg::BLINK_LAST_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            page_reg    <= page_next;
            pos_reg     <= pos_next;
            frame_reg   <= frame_next;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == fbr_pkg::CFG_BLINK_ON)
                begin
                    blink_on_reg <= cfg_ch.data;
                end
                else if (cfg_ch.index == fbr_pkg::CFG_BLINK_LAST)
                begin
                    blink_last_reg <= cfg_ch.data;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the item's write and scan details
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wr_addr_reg  <= ADDR_W'(pix_lin);
            wr_bit_reg   <= flip[2:0];
            wr_on_reg    <= in_ch.pixel_on;
            wr_mask_reg  <= in_ch.operation == fbr_pkg::OP_FLASH;
            wr_ok_reg    <= pix_ok;
            sc_data_reg  <= pos_is_data;
            sc_cmd_reg   <= cmd_byte;
            sc_last_reg  <= pos_end && page_end;
            sc_blank_reg <= !(frame_reg < blink_on_reg);
            sc_ok_reg    <= 32'(scan_lin) < 32'(STORE_BYTES);
        end
        if (out_load)
        begin
            out_byte_reg <= scan_byte;
            out_data_reg <= sc_data_reg;
            out_last_reg <= sc_last_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.lcd_byte   = out_byte_reg;
    assign out_ch.is_data    = out_data_reg;
    assign out_ch.frame_last = out_last_reg;

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fbr_pkg::ST_CLEAR |-> !in_ch.ready)
        else $error("input taken during clearing pass");

    a_scan_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbr_pkg::ST_SCAN && out_free) |=> out_valid_reg)
        else $error("scan result not registered");

    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> out_data_reg)
        else $error("frame end on a command byte");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) <= POS_MAX)
        else $error("scan position out of range");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int PANEL_COLUMNS = 128;
    localparam int PANEL_ROWS    = 64;
    localparam int STORE_BYTES   = 1024;
    localparam int PAGES         = PANEL_ROWS / 8;
    localparam int CLEAR_WAIT    = STORE_BYTES + 64;

    typedef logic [fbr_pkg::CFG_DATA_W-1:0] cfg_data_t;

    typedef struct packed {
        fbr_pkg::op_t op;
        logic [7:0]   row;
        logic [7:0]   col;
        logic         on;
    } pix_cmd_t;

    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       frame_last;
    } scan_byte_t;

    logic clk;
    logic rst_n;

    fbr_in_if  in_ch();
    fbr_out_if out_ch();
    fbr_cfg_if cfg_ch();

    framebuffer_blink_refresh_unit #(
        .PANEL_COLUMNS(PANEL_COLUMNS),
        .PANEL_ROWS(PANEL_ROWS),
        .STORE_BYTES(STORE_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_ch(cfg_ch)
    );

    pix_cmd_t   cmd_queue[$];
    scan_byte_t scan_expected[$];

    logic [7:0]                  pixel_mem [STORE_BYTES];
    logic [7:0]                  flash_mem [STORE_BYTES];
    int                          page_ctr;
    int                          col_ctr;
    int                          blink_ctr;
    logic [fbr_pkg::FRAME_W-1:0] blink_on;
    logic [fbr_pkg::FRAME_W-1:0] blink_last;

    bit         idling;
    bit         in_took;
    bit         out_took;
    int         in_wait;
    int         out_hold;
    int         hold_draw;
    int         failures;
    pix_cmd_t   next_cmd;
    pix_cmd_t   seen_cmd;
    scan_byte_t want;
    logic [7:0] last_row;
    logic [7:0] last_col;

    function automatic void paint(input bit to_mask, input logic [7:0] row,
                                  input logic [7:0] col, input logic on);
        int flipped;
        int addr;
        if (row >= PANEL_COLUMNS || col >= PANEL_ROWS)
            return;
        flipped = PANEL_ROWS - 1 - int'(col);
        addr    = (flipped / 8) * PANEL_COLUMNS + int'(row);
        if (addr >= STORE_BYTES)
            return;
        if (to_mask)
            flash_mem[addr][flipped % 8] = on;
        else
            pixel_mem[addr][flipped % 8] = on;
    endfunction

    function automatic scan_byte_t scan_step();
        scan_byte_t r;
        int         addr;
        r = '0;
        if (col_ctr == 0)
            r.lcd_byte = fbr_pkg::CMD_PAGE_BASE + 8'(page_ctr);
        else if (col_ctr == 1)
            r.lcd_byte = fbr_pkg::CMD_COL_HIGH;
        else if (col_ctr == 2)
            r.lcd_byte = fbr_pkg::CMD_COL_LOW;
        else
        begin
            r.is_data = 1'b1;
            addr = page_ctr * PANEL_COLUMNS + col_ctr - fbr_pkg::CMD_COUNT;
            if (addr < STORE_BYTES)
            begin
                if (blink_ctr < blink_on)
                    r.lcd_byte = pixel_mem[addr];
                else
                    r.lcd_byte = pixel_mem[addr] & ~flash_mem[addr];
            end
        end
        if (col_ctr >= fbr_pkg::CMD_COUNT + PANEL_COLUMNS - 1)
        begin
            col_ctr = 0;
            if (page_ctr + 1 >= PAGES)
            begin
                page_ctr     = 0;
                r.frame_last = 1'b1;
                if (blink_ctr >= blink_last)
                    blink_ctr = 0;
                else
                    blink_ctr = (blink_ctr + 1) & 15;
            end
            else
                page_ctr++;
        end
        else
            col_ctr++;
        return r;
    endfunction

    function automatic void wipe_stores();
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            pixel_mem[i] = '0;
            flash_mem[i] = '0;
        end
    endfunction

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $display("%0t %s expected %02h actual %02h", $time, name, exp_v, got_v);
            failures++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // advance the predictor on every accepted item and check every result
    always @(posedge clk)
    begin
        in_took  <= in_ch.valid && in_ch.ready;
        out_took <= out_ch.valid && out_ch.ready;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    fbr_pkg::CFG_BLINK_ON:   blink_on   = cfg_ch.data;
                    fbr_pkg::CFG_BLINK_LAST: blink_last = cfg_ch.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                seen_cmd.op  = in_ch.operation;
                seen_cmd.row = in_ch.pixel_row;
                seen_cmd.col = in_ch.pixel_col;
                seen_cmd.on  = in_ch.pixel_on;
                case (seen_cmd.op)
                    fbr_pkg::OP_DRAW:  paint(1'b0, seen_cmd.row, seen_cmd.col, seen_cmd.on);
                    fbr_pkg::OP_FLASH: paint(1'b1, seen_cmd.row, seen_cmd.col, seen_cmd.on);
                    fbr_pkg::OP_CLEAR: wipe_stores();
                    fbr_pkg::OP_TICK:  scan_expected.push_back(scan_step());
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (scan_expected.size() == 0)
                begin
                    $display("%0t unexpected item expected none actual %02h/%0b/%0b", $time,
                             out_ch.lcd_byte, out_ch.is_data, out_ch.frame_last);
                    failures++;
                end
                else
                begin
                    want = scan_expected.pop_front();
                    check_field("lcd_byte", int'(want.lcd_byte), int'(out_ch.lcd_byte));
                    check_field("is_data", int'(want.is_data), int'(out_ch.is_data));
                    check_field("frame_last", int'(want.frame_last),
                                int'(out_ch.frame_last));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || in_took))
        begin
            if (in_wait > 0)
            begin
                in_ch.valid <= 1'b0;
                in_wait     <= in_wait - 1;
            end
            else if (cmd_queue.size() > 0)
            begin
                next_cmd = cmd_queue.pop_front();
                in_ch.operation <= next_cmd.op;
                in_ch.pixel_row <= next_cmd.row;
                in_ch.pixel_col <= next_cmd.col;
                in_ch.pixel_on  <= next_cmd.on;
                in_ch.valid     <= 1'b1;
                in_wait         <= idling ? int'($urandom_range(0, 11)) : 0;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
            begin
                hold_draw = idling ? int'($urandom_range(0, 11)) : 0;
                if (hold_draw > 0)
                begin
                    out_ch.ready <= 1'b0;
                    out_hold     <= hold_draw - 1;
                end
                else
                    out_ch.ready <= 1'b1;
            end
            else if (out_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                out_hold     <= out_hold - 1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic push_cmd(input fbr_pkg::op_t op, input int row, input int col,
                            input int on);
        pix_cmd_t c;
        c.op  = op;
        c.row = 8'(row);
        c.col = 8'(col);
        c.on  = (on != 0);
        cmd_queue.push_back(c);
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_cmd(fbr_pkg::OP_TICK, int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)), int'($urandom_range(0, 1)));
    endtask

    // flash often reuses the last drawn pixel so the mask actually bites
    task automatic push_mix(input int n, input int tick_pct);
        pix_cmd_t c;
        int       r;
        for (int i = 0; i < n; i++)
        begin
            r     = int'($urandom_range(0, 99));
            c.row = 8'($urandom_range(0, 255));
            c.col = 8'($urandom_range(0, 255));
            c.on  = ($urandom_range(0, 1) != 0);
            if (r < 1)
                c.op = fbr_pkg::OP_CLEAR;
            else if (r < 1 + tick_pct)
                c.op = fbr_pkg::OP_TICK;
            else
            begin
                c.op = ($urandom_range(0, 1) != 0) ? fbr_pkg::OP_FLASH : fbr_pkg::OP_DRAW;
                if ($urandom_range(0, 9) != 0)
                begin
                    c.row = 8'($urandom_range(0, PANEL_COLUMNS - 1));
                    c.col = 8'($urandom_range(0, PANEL_ROWS - 1));
                    c.on  = ($urandom_range(0, 4) != 0);
                end
                if (c.op == fbr_pkg::OP_FLASH && $urandom_range(0, 1) != 0)
                begin
                    c.row = last_row;
                    c.col = last_col;
                end
                if (c.op == fbr_pkg::OP_DRAW)
                begin
                    last_row = c.row;
                    last_col = c.col;
                end
            end
            cmd_queue.push_back(c);
        end
    endtask

    // hold until every item is in and checked, then let a clear sweep finish
    task automatic settle();
        while (cmd_queue.size() != 0 || in_ch.valid || scan_expected.size() != 0)
            @(posedge clk);
        repeat (CLEAR_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fbr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fbr_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input int on_frames, input int last_frame, input bit idle,
                             input int mix_n, input int tick_n);
        write_reg(fbr_pkg::CFG_BLINK_ON, cfg_data_t'(on_frames));
        write_reg(fbr_pkg::CFG_BLINK_LAST, cfg_data_t'(last_frame));
        idling = idle;
        push_mix(mix_n, 35);
        push_ticks(tick_n);
        settle();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.operation  = fbr_pkg::OP_DRAW;
        in_ch.pixel_row  = '0;
        in_ch.pixel_col  = '0;
        in_ch.pixel_on   = 1'b0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = fbr_pkg::CFG_BLINK_ON;
        cfg_ch.data      = '0;
        in_took          = 1'b0;
        out_took         = 1'b0;
        in_wait          = 0;
        out_hold         = 0;
        failures         = 0;
        idling           = 1'b1;
        last_row         = '0;
        last_col         = '0;
        page_ctr         = 0;
        col_ctr          = 0;
        blink_ctr        = 0;
        blink_on         = fbr_pkg::BLINK_ON_RESET;
        blink_last       = fbr_pkg::BLINK_LAST_RESET;
        wipe_stores();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corners, off-panel writes, bit clear, mask, clear and the scan head
        push_cmd(fbr_pkg::OP_DRAW, 0, 0, 1);
        push_cmd(fbr_pkg::OP_DRAW, 127, 63, 1);
        push_cmd(fbr_pkg::OP_DRAW, 127, 0, 1);
        push_cmd(fbr_pkg::OP_DRAW, 0, 63, 1);
        push_cmd(fbr_pkg::OP_DRAW, 1, 63, 1);
        push_cmd(fbr_pkg::OP_DRAW, 128, 5, 1);
        push_cmd(fbr_pkg::OP_DRAW, 255, 255, 1);
        push_cmd(fbr_pkg::OP_DRAW, 5, 64, 1);
        push_cmd(fbr_pkg::OP_DRAW, 3, 255, 1);
        push_cmd(fbr_pkg::OP_DRAW, 127, 63, 0);
        push_cmd(fbr_pkg::OP_FLASH, 0, 63, 1);
        push_cmd(fbr_pkg::OP_FLASH, 127, 0, 1);
        push_cmd(fbr_pkg::OP_FLASH, 200, 10, 1);
        push_ticks(6);
        push_cmd(fbr_pkg::OP_CLEAR, 255, 255, 1);
        push_ticks(2);
        push_cmd(fbr_pkg::OP_DRAW, 5, 63, 1);
        push_ticks(2);
        settle();

        run_phase(0, 0, 1'b1, 100, 0);
        run_phase(15, 15, 1'b1, 100, 0);
        run_phase(1, 2, 1'b0, 60, 140);
        run_phase(2, 0, 1'b1, 0, 60);
        run_phase(4, 6, 1'b0, 80, 0);
        run_phase(15, 0, 1'b1, 60, 0);
        run_phase(int'($urandom_range(0, 15)), int'($urandom_range(0, 15)), 1'b1, 40, 40);

        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fbr_pkg.sv
sv/fbr_in_if.sv
sv/fbr_out_if.sv
sv/fbr_cfg_if.sv
sv/fbr_ram.sv
sv/framebuffer_blink_refresh_unit.sv
test/tb_top.sv
